/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the running k-smallest sum block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RKS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("%m: assertion failed");

`define RKS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define RKS_ASSERT(lbl, clk, rstn, prop)

`define RKS_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* hdl/rks_pkg.sv */
// ----------------------------------------------------------------------------
// rks_pkg
// shared widths and cell control type for the running k-smallest sum block
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int VALUE_W    = 17;
  localparam int SUM_W      = 25;
  localparam int KCNT_W     = 9;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [KCNT_W-1:0] KCNT_RESET = 9'd1;

  typedef struct packed {
    logic grow;
    logic replace;
  } cell_ctl_t;

endpackage

/* hdl/rks_cell.sv */
// ----------------------------------------------------------------------------
// rks_cell
// one slot of the descending sorted value row, shifting with its neighbors
// ----------------------------------------------------------------------------
module rks_cell #(
  parameter int VW    = 17,
  parameter int CNT_W = 9,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  rks_pkg::cell_ctl_t ctl,
  input  logic [VW-1:0]      v,
  input  logic [CNT_W-1:0]   eff_count,
  input  logic               prev_g,
  input  logic [VW-1:0]      prev_val,
  input  logic               next_g,
  input  logic [VW-1:0]      next_val,
  output logic [VW-1:0]      val,
  output logic               g
);

  logic [VW-1:0] val_r;
  logic [VW-1:0] val_nxt;
  logic          valid;

  assign valid = eff_count > CNT_W'(IDX);
  assign g     = valid && (val_r > v);
  assign val   = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.grow) begin
      // larger values stay, v lands after them, smaller ones move down
      if (g) val_nxt = val_r;
      else if (prev_g) val_nxt = v;
      else val_nxt = prev_val;
    end else if (ctl.replace) begin
      // head drops out, larger values move up, v fills its place
      if (next_g) val_nxt = next_val;
      else if (g) val_nxt = v;
      else val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* hdl/running_k_smallest_sum.sv */
// ----------------------------------------------------------------------------
// running_k_smallest_sum
// running sum of the k smallest values of a stream, kept in a sorted cell row
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)    | tuser      | notes
//  in_     | in  | value                 | start_req  | one item per value
//  out_    | out | sum_smallest          | full_res   | one item per input item
//  cfg_    | in  | k_count (cfg_data)    | -          | always ready
//
//  one item per cycle while in_tready is high; the cell row compares and shifts
//  as the item is taken, and the largest held value always sits in cell 0
//  the result appears in the cycle after the item is taken, in an output register
//  in_tready falls only while a result waits and out_tready is low
//  synchronous active-low reset clears count, sum and k (to 1); no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module running_k_smallest_sum #(
  parameter int K_MAX      = 256,
  parameter int VALUE_BITS = 17
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rks_pkg::IN_DATA_W-1:0]    in_tdata,   // value
  input  logic                             in_tuser,   // start_req
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rks_pkg::OUT_DATA_W-1:0]   out_tdata,  // sum_smallest
  output logic                             out_tuser,  // full_res
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rks_pkg::KCNT_W-1:0]       cfg_data
);

  localparam int VW    = VALUE_BITS;
  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int CW    = (CNT_W > rks_pkg::KCNT_W) ? CNT_W : rks_pkg::KCNT_W;
  localparam int AW    = (VW > rks_pkg::SUM_W) ? VW : rks_pkg::SUM_W;

  logic [rks_pkg::KCNT_W-1:0] k_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;
  logic [rks_pkg::SUM_W-1:0]  sum_r;
  logic [rks_pkg::SUM_W-1:0]  sum_nxt;
  logic                       out_valid_r;
  logic [rks_pkg::SUM_W-1:0]  out_sum_r;
  logic                       out_full_r;

  logic [VW-1:0]      v;
  logic               in_acc;
  logic [CW-1:0]      k_ext;
  logic [CNT_W-1:0]   k_eff;
  logic [CNT_W-1:0]   eff_count;
  logic [rks_pkg::SUM_W-1:0] base_sum;
  logic               grow;
  logic               replace;
  rks_pkg::cell_ctl_t ctl;
  logic [AW-1:0]      v_a;
  logic [AW-1:0]      head_a;
  logic [AW-1:0]      sum_a;

  logic [VW-1:0] cell_val [K_MAX];
  logic          cell_g   [K_MAX];

  generate
    if (VW <= rks_pkg::VALUE_W) begin : g_val_narrow
      assign v = in_tdata[VW-1:0];
    end else begin : g_val_wide
      assign v = {{(VW - rks_pkg::VALUE_W){1'b0}}, in_tdata[rks_pkg::VALUE_W-1:0]};
    end
  endgenerate

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign k_ext = CW'(k_r);

  always_comb begin
    if (k_r == '0) k_eff = CNT_W'(1);
    else if (k_ext > CW'(K_MAX)) k_eff = CNT_W'(K_MAX);
    else k_eff = CNT_W'(k_ext);
  end

  assign eff_count = in_tuser ? '0 : cnt_r;
  assign base_sum  = in_tuser ? '0 : sum_r;
  assign grow      = eff_count < k_eff;
  assign replace   = !grow && cell_g[0];

  assign ctl.grow    = in_acc && grow;
  assign ctl.replace = in_acc && replace;

  assign v_a    = AW'(v);
  assign head_a = AW'(cell_val[0]);

  always_comb begin
    sum_a = AW'(base_sum);
    if (grow) sum_a = sum_a + v_a;
    else if (replace) sum_a = sum_a - head_a + v_a;
  end

  assign sum_nxt = sum_a[rks_pkg::SUM_W-1:0];
  assign cnt_nxt = grow ? (eff_count + CNT_W'(1)) : eff_count;

  generate
    for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      logic          pg;
      logic [VW-1:0] pv;
      logic          ng;
      logic [VW-1:0] nv;
      if (i == 0) begin : g_first
        assign pg = 1'b1;
        assign pv = v;
      end else begin : g_mid_p
        assign pg = cell_g[i-1];
        assign pv = cell_val[i-1];
      end
      if (i == K_MAX - 1) begin : g_last
        assign ng = 1'b0;
        assign nv = v;
      end else begin : g_mid_n
        assign ng = cell_g[i+1];
        assign nv = cell_val[i+1];
      end
      rks_cell #(
        .VW    (VW),
        .CNT_W (CNT_W),
        .IDX   (i)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .v         (v),
        .eff_count (eff_count),
        .prev_g    (pg),
        .prev_val  (pv),
        .next_g    (ng),
        .next_val  (nv),
        .val       (cell_val[i]),
        .g         (cell_g[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= rks_pkg::KCNT_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) k_r <= cfg_data;
      if (in_acc) begin
        cnt_r       <= cnt_nxt;
        sum_r       <= sum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_sum_r  <= sum_nxt;
      out_full_r <= cnt_nxt >= k_eff;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rks_pkg::OUT_DATA_W - rks_pkg::SUM_W){1'b0}}, out_sum_r};
  assign out_tuser  = out_full_r;

  `RKS_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CNT_W'(K_MAX))
  `RKS_NEVER(a_ctl_excl, clk, rst_n, ctl.grow && ctl.replace)
  `RKS_ASSERT(a_out_after_acc, clk, rst_n, in_acc |=> out_tvalid)
  `RKS_ASSERT(a_cnt_hold, clk, rst_n, !in_acc |=> cnt_r == $past(cnt_r))

endmodule
